>>> src/mhpq_pkg.sv
// ----------------------------------------------------------------------------
// mhpq_pkg
// Shared types and codes for the max-heap priority queue core.
// ----------------------------------------------------------------------------
`default_nettype none

package mhpq_pkg;

  // request opcodes
  localparam logic OP_INSERT  = 1'b0;
  localparam logic OP_EXTRACT = 1'b1;

  // result status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXT_LD,
    ST_UP_CHK,
    ST_UP_CMP,
    ST_DN_CHK,
    ST_DN_PICK,
    ST_DN_CMP
  } state_t;

endpackage

`default_nettype wire

>>> src/max_heap_priority_queue_core.sv
// ----------------------------------------------------------------------------
// max_heap_priority_queue_core
// Binary max-heap of signed 32-bit values: insert with sift-up, extract of
// the maximum with sift-down, one shared signed comparator under a sequencer.
// ----------------------------------------------------------------------------
// insert climbs L levels, UP_CHK then UP_CMP per level, from accept to done;
//   extract runs EXT_LD, then DN_CHK, DN_PICK, DN_CMP per level, L <= log2(DEPTH)
// full insert and empty extract report done in the cycle after accept
// throughput: one request at a time; busy stays high until the last store write,
//   set per level by the shared comparator and the single store write port
// reset empties the heap (count to zero); done is a one-cycle strobe, never stalled
`default_nettype none

module max_heap_priority_queue_core #(
  parameter int DEPTH = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               op,
  input  wire logic signed [31:0] value,
  output logic                    done,
  output logic signed [31:0]      result_value,
  output logic [1:0]              status
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int LW = IW + 2;

  mhpq_pkg::state_t state, state_next;

  logic [CW-1:0] count, count_next;
  logic [IW-1:0] pos, pos_next;
  logic [31:0]   cur, cur_next;
  logic [31:0]   ext_val, ext_val_next;
  logic [IW-1:0] pick_idx, pick_idx_next;
  logic [31:0]   pick_val, pick_val_next;
  logic          done_next;
  logic [31:0]   res_next;
  logic [1:0]    stat_next;

  // store ports
  logic          we;
  logic [IW-1:0] waddr;
  logic [31:0]   wdata;
  logic [IW-1:0] raddr_a, raddr_b;
  logic [31:0]   rdata_a, rdata_b;

  // tree index arithmetic
  logic [IW-1:0] pos_m1;
  logic [IW-1:0] parent;
  logic [LW-1:0] left_w, right_w, count_w;
  logic [CW-1:0] count_m1;

  // shared signed comparator
  logic [31:0] cmp_a, cmp_b;
  logic        cmp_lt;

  mhpq_ram #(
    .DEPTH (DEPTH),
    .AW    (IW)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  assign pos_m1   = pos - IW'(1);
  assign parent   = pos_m1 >> 1;
  assign left_w   = LW'({pos, 1'b1});
  assign right_w  = LW'({pos, 1'b0}) + LW'(2);
  assign count_w  = LW'(count);
  assign count_m1 = count - CW'(1);

  assign busy = (state != mhpq_pkg::ST_IDLE);

  // comparator operand select
  always_comb begin
    cmp_a = rdata_a;
    cmp_b = cur;
    unique case (state)
      mhpq_pkg::ST_DN_PICK: begin
        cmp_a = rdata_b;
        cmp_b = rdata_a;
      end
      mhpq_pkg::ST_DN_CMP: begin
        cmp_a = cur;
        cmp_b = pick_val;
      end
      default: begin
        cmp_a = rdata_a;
        cmp_b = cur;
      end
    endcase
  end

  assign cmp_lt = ($signed(cmp_a) < $signed(cmp_b));

  // state register and control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mhpq_pkg::ST_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    pos      <= pos_next;
    cur      <= cur_next;
    ext_val  <= ext_val_next;
    pick_idx <= pick_idx_next;
    pick_val <= pick_val_next;
    if (done_next) begin
      result_value <= res_next;
      status       <= stat_next;
    end
  end

  // sequencer
  always_comb begin
    state_next    = state;
    count_next    = count;
    pos_next      = pos;
    cur_next      = cur;
    ext_val_next  = ext_val;
    pick_idx_next = pick_idx;
    pick_val_next = pick_val;
    done_next     = 1'b0;
    res_next      = '0;
    stat_next     = mhpq_pkg::STATUS_OK;
    we            = 1'b0;
    waddr         = pos;
    wdata         = cur;
    raddr_a       = '0;
    raddr_b       = '0;

    unique case (state)
      mhpq_pkg::ST_IDLE: begin
        // read root and last entry ahead of a possible extract
        raddr_a = '0;
        raddr_b = count_m1[IW-1:0];
        if (start) begin
          if (op == mhpq_pkg::OP_INSERT) begin
            if (count >= CW'(DEPTH)) begin
              done_next = 1'b1;
              stat_next = mhpq_pkg::STATUS_FULL;
            end else begin
              pos_next   = count[IW-1:0];
              cur_next   = value;
              count_next = count + CW'(1);
              state_next = mhpq_pkg::ST_UP_CHK;
            end
          end else begin
            if (count == '0) begin
              done_next = 1'b1;
              stat_next = mhpq_pkg::STATUS_EMPTY;
            end else begin
              count_next = count_m1;
              state_next = mhpq_pkg::ST_EXT_LD;
            end
          end
        end
      end

      mhpq_pkg::ST_EXT_LD: begin
        // root is the result, last entry restarts at the root
        ext_val_next = rdata_a;
        cur_next     = rdata_b;
        pos_next     = '0;
        state_next   = mhpq_pkg::ST_DN_CHK;
      end

      mhpq_pkg::ST_UP_CHK: begin
        raddr_a = parent;
        if (pos == '0) begin
          we         = 1'b1;
          done_next  = 1'b1;
          state_next = mhpq_pkg::ST_IDLE;
        end else begin
          state_next = mhpq_pkg::ST_UP_CMP;
        end
      end

      mhpq_pkg::ST_UP_CMP: begin
        // parent smaller: move parent down a level
        we = 1'b1;
        if (cmp_lt) begin
          wdata      = rdata_a;
          pos_next   = parent;
          state_next = mhpq_pkg::ST_UP_CHK;
        end else begin
          done_next  = 1'b1;
          state_next = mhpq_pkg::ST_IDLE;
        end
      end

      mhpq_pkg::ST_DN_CHK: begin
        raddr_a = left_w[IW-1:0];
        raddr_b = right_w[IW-1:0];
        if (left_w >= count_w) begin
          we         = 1'b1;
          done_next  = 1'b1;
          res_next   = ext_val;
          state_next = mhpq_pkg::ST_IDLE;
        end else begin
          state_next = mhpq_pkg::ST_DN_PICK;
        end
      end

      mhpq_pkg::ST_DN_PICK: begin
        // right child wins ties
        if ((right_w < count_w) && !cmp_lt) begin
          pick_idx_next = right_w[IW-1:0];
          pick_val_next = rdata_b;
        end else begin
          pick_idx_next = left_w[IW-1:0];
          pick_val_next = rdata_a;
        end
        state_next = mhpq_pkg::ST_DN_CMP;
      end

      mhpq_pkg::ST_DN_CMP: begin
        // larger child moves up a level
        we = 1'b1;
        if (cmp_lt) begin
          wdata      = pick_val;
          pos_next   = pick_idx;
          state_next = mhpq_pkg::ST_DN_CHK;
        end else begin
          done_next  = 1'b1;
          res_next   = ext_val;
          state_next = mhpq_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = mhpq_pkg::ST_IDLE;
      end
    endcase
  end

  // checks
  a_start_sets_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted request produced neither busy nor done");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above depth");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (done && status == mhpq_pkg::STATUS_FULL) |-> (count == CW'(DEPTH)))
    else $error("full status while heap not full");

  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    (done && status == mhpq_pkg::STATUS_EMPTY) |-> (count == '0 && result_value == '0))
    else $error("empty status with entries or nonzero result");

endmodule

`default_nettype wire

>>> src/mhpq_ram.sv
// ----------------------------------------------------------------------------
// mhpq_ram
// Heap entry store: one write port, two read ports with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module mhpq_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [31:0]   wdata,
  input  wire logic [AW-1:0] raddr_a,
  input  wire logic [AW-1:0] raddr_b,
  output logic      [31:0]   rdata_a,
  output logic      [31:0]   rdata_b
);

  logic [31:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read ports
  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire
